// ===== sv/assert_macros.svh =====
// assertion macros for rtl files that check themselves (included by the top level)
// expects i_clk and i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/isx_pkg.sv =====
// shared constants, codes and types of the spin exchange block
// no dependencies
package isx_pkg;

    localparam int SIDE       = 128;
    localparam int ADDR_W     = $clog2(SIDE);
    localparam int CMD_W      = 2;
    localparam int ROW_W      = 7;
    localparam int COL_W      = 7;
    localparam int DIR_W      = 2;
    localparam int RND_W      = 16;
    localparam int THR_W      = 16;
    localparam int OUT_W      = 3;
    localparam int DE_W       = 5;
    localparam int ACC_W      = 18;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CMD_W-1:0] CMD_INIT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EXCH = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

    localparam logic [DIR_W-1:0] DIR_COL_UP   = 2'd0;
    localparam logic [DIR_W-1:0] DIR_COL_DOWN = 2'd1;
    localparam logic [DIR_W-1:0] DIR_ROW_UP   = 2'd2;
    localparam logic [DIR_W-1:0] DIR_ROW_DOWN = 2'd3;

    localparam logic [OUT_W-1:0] OUT_SKIP   = 3'd0;
    localparam logic [OUT_W-1:0] OUT_ACC    = 3'd1;
    localparam logic [OUT_W-1:0] OUT_REJ    = 3'd2;
    localparam logic [OUT_W-1:0] OUT_REFUSE = 3'd3;
    localparam logic [OUT_W-1:0] OUT_DONE   = 3'd4;

    localparam logic [1:0] REG_THR4  = 2'd0;
    localparam logic [1:0] REG_THR8  = 2'd1;
    localparam logic [1:0] REG_THR12 = 2'd2;

    typedef enum logic [2:0] {
        K_INIT,
        K_EXCH,
        K_REFUSE,
        K_READ,
        K_NOP
    } t_kind;

    // one classified request; rows are held as base-1 .. base+2 in the back end
    typedef struct packed {
        t_kind              kind;
        logic [ADDR_W-1:0]  base;
        logic               lo1;    // site in row base+1 instead of base
        logic               lo2;    // partner in row base+1 instead of base
        logic [ADDR_W-1:0]  c1;
        logic [ADDR_W-1:0]  c2;
        logic [RND_W-1:0]   rnd;
        logic               rd_ok;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== sv/isx_ifs.sv =====
// request and result channel interfaces
// depends on isx_pkg
interface isx_in_if;
    logic                         valid;
    logic                         ready;
    logic [isx_pkg::CMD_W-1:0]    cmd;
    logic [isx_pkg::ROW_W-1:0]    row;
    logic [isx_pkg::COL_W-1:0]    col;
    logic [isx_pkg::DIR_W-1:0]    direction;
    logic [isx_pkg::RND_W-1:0]    random_word;
    modport source (output valid, cmd, row, col, direction, random_word, input ready);
    modport sink   (input valid, cmd, row, col, direction, random_word, output ready);
endinterface

interface isx_out_if;
    logic                             valid;
    logic                             ready;
    logic [isx_pkg::OUT_W-1:0]        outcome;
    logic signed [isx_pkg::DE_W-1:0]  energy_change;
    logic signed [isx_pkg::ACC_W-1:0] energy_sum;
    logic                             spin_value;
    modport source (output valid, outcome, energy_change, energy_sum, spin_value,
                    input ready);
    modport sink   (input valid, outcome, energy_change, energy_sum, spin_value,
                    output ready);
endinterface

// ===== sv/isx_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module isx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/isx_front.sv =====
// front end: takes requests and classifies them into jobs
// depends on isx_pkg and isx_ifs
module isx_front (
    isx_in_if.sink              i_in,
    input  isx_pkg::t_fifo_stat i_fstat,
    output logic                o_push,
    output isx_pkg::t_job       o_job
);
    localparam logic [isx_pkg::ROW_W-1:0] ROW_LAST_IN = isx_pkg::ROW_W'(isx_pkg::SIDE - 2);
    localparam logic [isx_pkg::ROW_W-1:0] ROW_PRE_IN  = isx_pkg::ROW_W'(isx_pkg::SIDE - 3);

    logic                        w_ok;
    logic [isx_pkg::ADDR_W-1:0]  w_row;

    assign w_row  = isx_pkg::ADDR_W'(i_in.row);
    assign i_in.ready = !i_fstat.full;
    assign o_push = i_in.valid && !i_fstat.full;

    always_comb begin
        w_ok = (i_in.row >= isx_pkg::ROW_W'(1)) && (i_in.row <= ROW_LAST_IN);
        unique case (i_in.direction)
            isx_pkg::DIR_ROW_UP:   w_ok = w_ok && (i_in.row <= ROW_PRE_IN);
            isx_pkg::DIR_ROW_DOWN: w_ok = w_ok && (i_in.row >= isx_pkg::ROW_W'(2));
            default:               w_ok = w_ok;
        endcase
    end

    always_comb begin
        o_job       = '0;
        o_job.rnd   = i_in.random_word;
        o_job.c1    = isx_pkg::ADDR_W'(i_in.col);
        o_job.c2    = isx_pkg::ADDR_W'(i_in.col);
        o_job.base  = w_row;
        o_job.rd_ok = ({1'b0, i_in.row} < (isx_pkg::ROW_W + 1)'(isx_pkg::SIDE));
        unique case (i_in.cmd)
            isx_pkg::CMD_INIT: o_job.kind = isx_pkg::K_INIT;
            isx_pkg::CMD_READ: begin
                o_job.kind = isx_pkg::K_READ;
                // read row sits in slot base-1
                o_job.base = w_row + isx_pkg::ADDR_W'(1);
            end
            isx_pkg::CMD_EXCH: begin
                o_job.kind = w_ok ? isx_pkg::K_EXCH : isx_pkg::K_REFUSE;
                unique case (i_in.direction)
                    isx_pkg::DIR_COL_UP:   o_job.c2 = o_job.c1 + isx_pkg::ADDR_W'(1);
                    isx_pkg::DIR_COL_DOWN: o_job.c2 = o_job.c1 - isx_pkg::ADDR_W'(1);
                    isx_pkg::DIR_ROW_UP:   o_job.lo2 = 1'b1;
                    default: begin
                        o_job.base = w_row - isx_pkg::ADDR_W'(1);
                        o_job.lo1  = 1'b1;
                    end
                endcase
            end
            default: o_job.kind = isx_pkg::K_NOP;
        endcase
    end
endmodule

// ===== sv/isx_fifo.sv =====
// short job queue between front and back end
// depends on isx_pkg
module isx_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  isx_pkg::t_job       i_job,
    input  logic                i_pop,
    output isx_pkg::t_job       o_job,
    output isx_pkg::t_fifo_stat o_stat
);
    isx_pkg::t_job                 r_mem [isx_pkg::FIFO_DEPTH];
    logic [isx_pkg::FIFO_PTR_W-1:0] r_wp, r_rp;
    logic [isx_pkg::FIFO_PTR_W:0]   r_cnt, n_cnt;

    assign o_stat.full  = (r_cnt == (isx_pkg::FIFO_PTR_W + 1)'(isx_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_job = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end
endmodule

// ===== sv/isx_back.sv =====
// back end: sequencer over the row-wide lattice memory, result register
// depends on isx_pkg, isx_ifs and isx_ram
module isx_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  isx_pkg::t_job               i_job,
    input  isx_pkg::t_fifo_stat         i_fstat,
    output logic                        o_pop,
    input  logic [isx_pkg::THR_W-1:0]   i_thr4,
    input  logic [isx_pkg::THR_W-1:0]   i_thr8,
    input  logic [isx_pkg::THR_W-1:0]   i_thr12,
    isx_out_if.source                   o_out
);
    localparam int SIDE = isx_pkg::SIDE;
    localparam int AW   = isx_pkg::ADDR_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_INIT = 7'b0000010,
        S_READ = 7'b0000100,
        S_EVAL = 7'b0001000,
        S_WR0  = 7'b0010000,
        S_WR1  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state                          r_state, n_state;
    isx_pkg::t_job                   r_job;
    logic [AW-1:0]                   r_icnt;
    logic [2:0]                      r_rcnt;
    logic [SIDE-1:0]                 r_rows [4];
    logic signed [isx_pkg::ACC_W-1:0] r_acc;
    logic signed [isx_pkg::DE_W-1:0] r_de;
    logic [isx_pkg::OUT_W-1:0]       r_outc;
    logic                            r_spin;
    logic                            r_ovalid;
    logic [isx_pkg::OUT_W-1:0]       r_o_outc;
    logic signed [isx_pkg::DE_W-1:0] r_o_de;
    logic signed [isx_pkg::ACC_W-1:0] r_o_sum;
    logic                            r_o_spin;

    logic                            w_we;
    logic [AW-1:0]                   w_waddr, w_raddr;
    logic [SIDE-1:0]                 w_wdata, w_rdata;
    logic [SIDE-1:0]                 w_m1, w_m2, w_new0, w_new1;
    logic [SIDE-1:0]                 w_a1, w_u1, w_d1, w_a2, w_u2, w_d2;
    logic                            w_s1, w_s2;
    logic [2:0]                      w_o1, w_o2;
    logic signed [3:0]               w_diff, w_sd;
    logic signed [6:0]               w_de7;
    logic signed [isx_pkg::DE_W-1:0] w_de;
    logic                            w_accept;
    logic                            w_out_free;

    function automatic logic rnd_le(input logic [isx_pkg::THR_W-1:0] thr);
        rnd_le = (r_job.rnd <= thr);
    endfunction

    isx_ram #(.WIDTH(SIDE), .DEPTH(SIDE)) u_lattice (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_free = !r_ovalid || o_out.ready;
    assign o_pop      = (r_state == S_IDLE) && !i_fstat.empty;
    assign w_raddr    = r_job.base - AW'(1) + AW'(r_rcnt[1:0]);

    // neighbourhood of both sites out of the four held rows
    assign w_a1 = r_job.lo1 ? r_rows[2] : r_rows[1];
    assign w_u1 = r_job.lo1 ? r_rows[1] : r_rows[0];
    assign w_d1 = r_job.lo1 ? r_rows[3] : r_rows[2];
    assign w_a2 = r_job.lo2 ? r_rows[2] : r_rows[1];
    assign w_u2 = r_job.lo2 ? r_rows[1] : r_rows[0];
    assign w_d2 = r_job.lo2 ? r_rows[3] : r_rows[2];
    assign w_s1 = w_a1[r_job.c1];
    assign w_s2 = w_a2[r_job.c2];

    assign w_o1 = 3'(w_u1[r_job.c1]) + 3'(w_d1[r_job.c1])
                + 3'(w_a1[r_job.c1 - AW'(1)]) + 3'(w_a1[r_job.c1 + AW'(1)]);
    assign w_o2 = 3'(w_u2[r_job.c2]) + 3'(w_d2[r_job.c2])
                + 3'(w_a2[r_job.c2 - AW'(1)]) + 3'(w_a2[r_job.c2 + AW'(1)]);

    // spins opposite: dE = 4*s1*(ones1 - ones2) + 4
    assign w_diff = signed'({1'b0, w_o1}) - signed'({1'b0, w_o2});
    assign w_sd   = w_s1 ? w_diff : -w_diff;
    assign w_de7  = 7'(signed'({w_sd, 2'b00})) + 7'sd4;
    assign w_de   = w_de7[isx_pkg::DE_W-1:0];

    always_comb begin
        if (w_de <= 0) begin
            w_accept = 1'b1;
        end else if (w_de == 5'sd4) begin
            w_accept = rnd_le(i_thr4);
        end else if (w_de == 5'sd8) begin
            w_accept = rnd_le(i_thr8);
        end else begin
            w_accept = rnd_le(i_thr12);
        end
    end

    // accepted swap of opposite spins flips both bits
    always_comb begin
        w_m1   = '0;
        w_m2   = '0;
        w_m1[r_job.c1] = 1'b1;
        w_m2[r_job.c2] = 1'b1;
        w_new0 = r_rows[1] ^ (r_job.lo1 ? '0 : w_m1) ^ (r_job.lo2 ? '0 : w_m2);
        w_new1 = r_rows[2] ^ (r_job.lo1 ? w_m1 : '0) ^ (r_job.lo2 ? w_m2 : '0);
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_icnt;
        w_wdata = (r_icnt >= AW'(SIDE / 2)) ? '1 : '0;
        unique case (r_state)
            S_INIT: w_we = 1'b1;
            S_WR0: begin
                w_we    = 1'b1;
                w_waddr = r_job.base;
                w_wdata = w_new0;
            end
            S_WR1: begin
                w_we    = 1'b1;
                w_waddr = r_job.base + AW'(1);
                w_wdata = w_new1;
            end
            default: w_we = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_fstat.empty) begin
                    unique case (i_job.kind)
                        isx_pkg::K_INIT:                 n_state = S_INIT;
                        isx_pkg::K_EXCH, isx_pkg::K_READ: n_state = S_READ;
                        default:                         n_state = S_OUT;
                    endcase
                end
            end
            S_INIT: if (r_icnt == AW'(SIDE - 1)) n_state = S_OUT;
            S_READ: if (r_rcnt == 3'd4) n_state = S_EVAL;
            S_EVAL: begin
                if (r_job.kind == isx_pkg::K_EXCH && w_s1 != w_s2 && w_accept) begin
                    n_state = S_WR0;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_WR0:  n_state = S_WR1;
            S_WR1:  n_state = S_OUT;
            S_OUT:  if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT && r_icnt == '0) begin
                r_acc <= '0;
            end
            if (r_state == S_EVAL && r_job.kind == isx_pkg::K_EXCH
                && w_s1 != w_s2 && w_accept) begin
                r_acc <= r_acc + isx_pkg::ACC_W'(w_de);
            end
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job  <= i_job;
            r_icnt <= '0;
            r_rcnt <= '0;
            r_de   <= '0;
            r_spin <= 1'b0;
            r_outc <= (i_job.kind == isx_pkg::K_REFUSE) ? isx_pkg::OUT_REFUSE
                                                        : isx_pkg::OUT_DONE;
        end
        if (r_state == S_INIT) begin
            r_icnt <= r_icnt + AW'(1);
        end
        if (r_state == S_READ) begin
            r_rcnt <= r_rcnt + 3'd1;
            if (r_rcnt != 3'd0) begin
                r_rows[r_rcnt[1:0] - 2'd1] <= w_rdata;
            end
        end
        if (r_state == S_EVAL) begin
            if (r_job.kind == isx_pkg::K_READ) begin
                r_spin <= r_job.rd_ok & r_rows[0][r_job.c1];
            end else if (w_s1 == w_s2) begin
                r_outc <= isx_pkg::OUT_SKIP;
            end else begin
                r_de   <= w_de;
                r_outc <= w_accept ? isx_pkg::OUT_ACC : isx_pkg::OUT_REJ;
            end
        end
        if (r_state == S_OUT && w_out_free) begin
            r_o_outc <= r_outc;
            r_o_de   <= r_de;
            r_o_sum  <= r_acc;
            r_o_spin <= r_spin;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.outcome       = r_o_outc;
    assign o_out.energy_change = r_o_de;
    assign o_out.energy_sum    = r_o_sum;
    assign o_out.spin_value    = r_o_spin;
endmodule

// ===== sv/ising_spin_exchange_step.sv =====
// top level of the lattice spin exchange engine with its register port
// depends on isx_pkg, isx_ifs, isx_front, isx_fifo, isx_back, assert_macros.svh
//
//  channel   dir  handshake              carries
//  i_in      in   valid/ready            cmd, row, col, direction, random_word
//  o_out     out  valid/ready            outcome, energy_change, energy_sum, spin_value
//  apb       in   psel/penable/pready    threshold registers at 0x0, 0x4, 0x8
//
// an accepted exchange picks up the job, streams four lattice rows through the
// registered memory read port, evaluates, writes two rows back and loads the
// result register; a skipped or rejected one and a read skip the write-backs,
// refused and unused commands go straight to the result register, and init
// writes every row. reset clears control, the queue and the energy sum; the
// lattice holds junk until the first init. a result held by the receiver stalls
// the back end in its output state; requests stall once the queue of two fills.
`include "assert_macros.svh"

module ising_spin_exchange_step (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    isx_in_if.sink                              i_in,
    isx_out_if.source                           o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [isx_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [isx_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [isx_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    logic [isx_pkg::THR_W-1:0] r_thr4, r_thr8, r_thr12;
    logic                      w_push, w_pop, w_wr;
    isx_pkg::t_job             w_fjob, w_qjob;
    isx_pkg::t_fifo_stat       w_fstat;
    logic [1:0]                w_idx;
    logic                      w_res_nonread, w_res_uneval;

    // register port: no wait states
    assign pready = 1'b1;
    assign w_idx  = paddr[3:2];
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr4  <= '0;
            r_thr8  <= '0;
            r_thr12 <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                isx_pkg::REG_THR4:  r_thr4  <= pwdata[isx_pkg::THR_W-1:0];
                isx_pkg::REG_THR8:  r_thr8  <= pwdata[isx_pkg::THR_W-1:0];
                isx_pkg::REG_THR12: r_thr12 <= pwdata[isx_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            isx_pkg::REG_THR4:  prdata = isx_pkg::CFG_DATA_W'(r_thr4);
            isx_pkg::REG_THR8:  prdata = isx_pkg::CFG_DATA_W'(r_thr8);
            isx_pkg::REG_THR12: prdata = isx_pkg::CFG_DATA_W'(r_thr12);
            default:            prdata = '0;
        endcase
    end

    // front classifies each request, queue decouples, back does the lattice work
    isx_front u_front (
        .i_in    (i_in),
        .i_fstat (w_fstat),
        .o_push  (w_push),
        .o_job   (w_fjob)
    );

    isx_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_fjob),
        .i_pop   (w_pop),
        .o_job   (w_qjob),
        .o_stat  (w_fstat)
    );

    isx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_qjob),
        .i_fstat (w_fstat),
        .o_pop   (w_pop),
        .i_thr4  (r_thr4),
        .i_thr8  (r_thr8),
        .i_thr12 (r_thr12),
        .o_out   (o_out)
    );

    // result kinds checked below
    assign w_res_nonread = o_out.valid && (o_out.outcome != isx_pkg::OUT_DONE);
    assign w_res_uneval  = o_out.valid && (o_out.outcome == isx_pkg::OUT_SKIP
                                           || o_out.outcome == isx_pkg::OUT_REFUSE);

    // queue must never take a job while full or give one while empty
    `ASSERT_ALWAYS(a_queue_push_ok, !(w_push && w_fstat.full), "push into full queue")
    `ASSERT_ALWAYS(a_queue_pop_ok, !(w_pop && w_fstat.empty), "pop from empty queue")
    // spin bit only carries data on a read result
    `ASSERT_IMPLIES(a_spin_only_read, w_res_nonread, o_out.spin_value == 1'b0, "spin on non-read")
    // skipped and refused exchanges report no energy step
    `ASSERT_IMPLIES(a_no_de_unevaluated, w_res_uneval, o_out.energy_change == '0, "unevaluated dE")
endmodule
